// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the matrix multiply engine.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/mme_pkg.sv
// Package of the matrix multiply engine: sizes, codes and pipeline types.
// It depends on nothing; the top level uses it by scoped names.
`default_nettype none

package mme_pkg;

	localparam int MAX_ROWS     = 16;
	localparam int MAX_INNER    = 64;
	localparam int MAX_COLUMNS  = 16;
	localparam int ELEMENT_BITS = 16;
	localparam int STORE_DEPTH  = 1024;
	localparam int ADDR_BITS    = $clog2(STORE_DEPTH);

	localparam int ACTION_BITS  = 2;
	localparam int ROWS_BITS    = 5;
	localparam int INNER_BITS   = 7;
	localparam int COLS_BITS    = 5;
	localparam int ROW_IDX_BITS = $clog2(MAX_ROWS);
	localparam int P_BITS       = $clog2(MAX_INNER);
	localparam int COL_IDX_BITS = 4;
	localparam int PROD_BITS    = 2 * ELEMENT_BITS;
	localparam int SUM_BITS     = 38;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 7;

	// Input actions.
	localparam logic [ACTION_BITS-1:0] ACT_WR_LEFT  = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_WR_RIGHT = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_COMPUTE  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_TRANS  = 2'd3;

	// Tag that travels with each pair of store reads down the pipeline.
	typedef struct packed {
		logic                    first;    // first term of a dot product
		logic                    last;     // last term of a dot product
		logic                    last_col; // dot product is the last of the row
		logic                    zero;     // inner length zero: the term counts as 0
		logic [COL_IDX_BITS-1:0] col;
	} mme_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/mme_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; it depends on no package.
`default_nettype none

module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/matrix_multiply_engine_top.sv
// Matrix multiply engine: load transactions write the stores at acceptance and never raise busy.
// A compute transaction on a valid row gives its sums in column order, one
// multiply-accumulate a cycle set by the single read port of each element store;
// a bad row gives its flagged result in the next cycle. The receiver cannot stall.
// Reset (arst_n low) clears the control state and the registers to 16, 64, 16, 0;
// the element stores keep no reset value.
`default_nettype none

module matrix_multiply_engine_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Command channel.
	input  wire logic                                  start,
	output      logic                                  busy,
	input  wire logic [mme_pkg::ACTION_BITS-1:0]       action,
	input  wire logic [mme_pkg::ADDR_BITS-1:0]         location,
	input  wire logic signed [mme_pkg::ELEMENT_BITS-1:0] element_value,
	// Configuration write channel.
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [mme_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [mme_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	// Result channel: one cycle per result, marked by done.
	output      logic                                  done,
	output      logic signed [mme_pkg::SUM_BITS-1:0]   dot_sum,
	output      logic [mme_pkg::COL_IDX_BITS-1:0]      column_number,
	output      logic                                  last_of_row,
	output      logic                                  bad_row
);

	`include "assert_macros.svh"

	typedef enum logic {
		ST_IDLE,
		ST_ISSUE
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back; the user writes
	// them only while the engine is idle.
	// ------------------------------------------------------------------
	logic [mme_pkg::ROWS_BITS-1:0]  row_count_q;
	logic [mme_pkg::INNER_BITS-1:0] inner_length_q;
	logic [mme_pkg::COLS_BITS-1:0]  column_count_q;
	logic                           right_trans_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= mme_pkg::ROWS_BITS'(mme_pkg::MAX_ROWS);
			inner_length_q <= mme_pkg::INNER_BITS'(mme_pkg::MAX_INNER);
			column_count_q <= mme_pkg::COLS_BITS'(mme_pkg::MAX_COLUMNS);
			right_trans_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mme_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data[mme_pkg::ROWS_BITS-1:0];
				mme_pkg::REG_INNER_LENGTH: inner_length_q <= cfg_data[mme_pkg::INNER_BITS-1:0];
				mme_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data[mme_pkg::COLS_BITS-1:0];
				mme_pkg::REG_RIGHT_TRANS:  right_trans_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective sizes: oversized values saturate, and zero columns act as one.
	logic [mme_pkg::ROWS_BITS-1:0]  rows_s;
	logic [mme_pkg::INNER_BITS-1:0] inner_s;
	logic [mme_pkg::COLS_BITS-1:0]  cols_s;

	always_comb begin
		rows_s  = (row_count_q > mme_pkg::ROWS_BITS'(mme_pkg::MAX_ROWS))
			? mme_pkg::ROWS_BITS'(mme_pkg::MAX_ROWS) : row_count_q;
		inner_s = (inner_length_q > mme_pkg::INNER_BITS'(mme_pkg::MAX_INNER))
			? mme_pkg::INNER_BITS'(mme_pkg::MAX_INNER) : inner_length_q;
		cols_s  = (column_count_q > mme_pkg::COLS_BITS'(mme_pkg::MAX_COLUMNS))
			? mme_pkg::COLS_BITS'(mme_pkg::MAX_COLUMNS) : column_count_q;
		if (cols_s == '0) begin
			cols_s = mme_pkg::COLS_BITS'(1);
		end
	end

	// ------------------------------------------------------------------
	// Command decode. Loads write the stores directly at acceptance.
	// ------------------------------------------------------------------
	logic cmd_accept;
	logic cmd_compute;
	logic row_bad;

	assign cmd_accept  = start && !busy;
	assign cmd_compute = cmd_accept && (action == mme_pkg::ACT_COMPUTE);
	assign row_bad     = location >= mme_pkg::ADDR_BITS'(rows_s);

	// ------------------------------------------------------------------
	// Issue sequencer state: one pair of element reads per cycle. The
	// addresses are kept incrementally and wrap at the store depth.
	// ------------------------------------------------------------------
	state_t                             state_q;
	logic [mme_pkg::P_BITS-1:0]         p_q;
	logic [mme_pkg::COL_IDX_BITS-1:0]   j_q;
	logic [mme_pkg::ADDR_BITS-1:0]      la_q;
	logic [mme_pkg::ADDR_BITS-1:0]      lbase_q;
	logic [mme_pkg::ADDR_BITS-1:0]      ra_q;
	logic [mme_pkg::ADDR_BITS-1:0]      rcol_q;
	logic [mme_pkg::INNER_BITS-1:0]     inner_q;
	logic [mme_pkg::INNER_BITS-1:0]     inner_m1_q;
	logic                               zero_inner_q;
	logic [mme_pkg::COLS_BITS-1:0]      cols_q;
	logic [mme_pkg::COL_IDX_BITS-1:0]   cols_m1_q;
	logic                               trans_q;

	logic               issuing;
	logic               last_p;
	logic               last_c;
	mme_pkg::mme_tag_t  issue_tag;

	assign issuing = (state_q == ST_ISSUE);
	assign last_p  = zero_inner_q || ({1'b0, p_q} == inner_m1_q);
	assign last_c  = (j_q == cols_m1_q);

	always_comb begin
		issue_tag.first    = (p_q == '0);
		issue_tag.last     = last_p;
		issue_tag.last_col = last_c;
		issue_tag.zero     = zero_inner_q;
		issue_tag.col      = j_q;
	end

	// ------------------------------------------------------------------
	// Element stores.
	// ------------------------------------------------------------------
	logic [mme_pkg::ELEMENT_BITS-1:0] left_rd;
	logic [mme_pkg::ELEMENT_BITS-1:0] right_rd;

	mme_ram #(
		.WIDTH(mme_pkg::ELEMENT_BITS),
		.DEPTH(mme_pkg::STORE_DEPTH)
	) u_left_store (
		.clk   (clk),
		.we    (cmd_accept && (action == mme_pkg::ACT_WR_LEFT)),
		.waddr (location),
		.wdata (element_value),
		.re    (issuing),
		.raddr (la_q),
		.rdata (left_rd)
	);

	mme_ram #(
		.WIDTH(mme_pkg::ELEMENT_BITS),
		.DEPTH(mme_pkg::STORE_DEPTH)
	) u_right_store (
		.clk   (clk),
		.we    (cmd_accept && (action == mme_pkg::ACT_WR_RIGHT)),
		.waddr (location),
		.wdata (element_value),
		.re    (issuing),
		.raddr (ra_q),
		.rdata (right_rd)
	);

	// ------------------------------------------------------------------
	// Datapath: stage 1 has the read data, stage 2 the product, and the
	// accumulator folds the product in and hands finished sums to the
	// output register.
	// ------------------------------------------------------------------
	logic                              v_s1;
	mme_pkg::mme_tag_t                 tag_s1;
	logic                              v_s2;
	mme_pkg::mme_tag_t                 tag_s2;
	logic signed [mme_pkg::PROD_BITS-1:0] prod_s2;
	logic signed [mme_pkg::SUM_BITS-1:0]  acc_q;
	logic signed [mme_pkg::SUM_BITS-1:0]  acc_sum;

	always_comb begin
		acc_sum = (tag_s2.first ? '0 : acc_q)
			+ {{(mme_pkg::SUM_BITS - mme_pkg::PROD_BITS){prod_s2[mme_pkg::PROD_BITS-1]}},
				prod_s2};
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (tag_s1.zero) begin
				prod_s2 <= '0;
			end else begin
				prod_s2 <= $signed(left_rd) * $signed(right_rd);
			end
		end
		if (v_s2) begin
			acc_q <= acc_sum;
		end
	end

	assign busy = issuing || v_s1 || v_s2;

	// ------------------------------------------------------------------
	// Sequencer, pipeline valids and the registered result outputs.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			p_q           <= '0;
			j_q           <= '0;
			la_q          <= '0;
			lbase_q       <= '0;
			ra_q          <= '0;
			rcol_q        <= '0;
			inner_q       <= '0;
			inner_m1_q    <= '0;
			zero_inner_q  <= 1'b0;
			cols_q        <= '0;
			cols_m1_q     <= '0;
			trans_q       <= 1'b0;
			v_s1          <= 1'b0;
			tag_s1        <= '0;
			v_s2          <= 1'b0;
			tag_s2        <= '0;
			done          <= 1'b0;
			dot_sum       <= '0;
			column_number <= '0;
			last_of_row   <= 1'b0;
			bad_row       <= 1'b0;
		end else begin
			done <= 1'b0;

			v_s1   <= issuing;
			tag_s1 <= issue_tag;
			v_s2   <= v_s1;
			tag_s2 <= tag_s1;

			case (state_q)
				ST_IDLE: begin
					if (cmd_compute && row_bad) begin
						done          <= 1'b1;
						dot_sum       <= '0;
						column_number <= '0;
						last_of_row   <= 1'b1;
						bad_row       <= 1'b1;
					end else if (cmd_compute) begin
						state_q      <= ST_ISSUE;
						p_q          <= '0;
						j_q          <= '0;
						lbase_q      <= mme_pkg::ADDR_BITS'(
							mme_pkg::ADDR_BITS'(location[mme_pkg::ROW_IDX_BITS-1:0])
							* mme_pkg::ADDR_BITS'(inner_s));
						la_q         <= mme_pkg::ADDR_BITS'(
							mme_pkg::ADDR_BITS'(location[mme_pkg::ROW_IDX_BITS-1:0])
							* mme_pkg::ADDR_BITS'(inner_s));
						ra_q         <= '0;
						rcol_q       <= '0;
						inner_q      <= inner_s;
						inner_m1_q   <= inner_s - mme_pkg::INNER_BITS'(1);
						zero_inner_q <= (inner_s == '0);
						cols_q       <= cols_s;
						cols_m1_q    <= mme_pkg::COL_IDX_BITS'(cols_s - mme_pkg::COLS_BITS'(1));
						trans_q      <= right_trans_q;
					end
				end
				ST_ISSUE: begin
					if (last_p) begin
						p_q  <= '0;
						j_q  <= j_q + mme_pkg::COL_IDX_BITS'(1);
						la_q <= lbase_q;
						if (trans_q) begin
							rcol_q <= rcol_q + mme_pkg::ADDR_BITS'(inner_q);
							ra_q   <= rcol_q + mme_pkg::ADDR_BITS'(inner_q);
						end else begin
							ra_q <= mme_pkg::ADDR_BITS'(j_q) + mme_pkg::ADDR_BITS'(1);
						end
						if (last_c) begin
							state_q <= ST_IDLE;
						end
					end else begin
						p_q  <= p_q + mme_pkg::P_BITS'(1);
						la_q <= la_q + mme_pkg::ADDR_BITS'(1);
						ra_q <= ra_q + (trans_q ? mme_pkg::ADDR_BITS'(1)
							: mme_pkg::ADDR_BITS'(cols_q));
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (v_s2 && tag_s2.last) begin
				done          <= 1'b1;
				dot_sum       <= acc_sum;
				column_number <= tag_s2.col;
				last_of_row   <= tag_s2.last_col;
				bad_row       <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`ASSERT_IMPLIES(a_bad_is_last, done && bad_row, last_of_row && (dot_sum == '0))
	`ASSERT_IMPLIES(a_last_col, done && !bad_row && last_of_row, column_number == cols_m1_q)
	`ASSERT_NEXT(a_sum_emitted, v_s2 && tag_s2.last, done && !bad_row)
	`ASSERT_NEXT(a_compute_busy, cmd_compute && !row_bad, busy)

endmodule

`default_nettype wire
